// ----- src/pnm_hp_pkg.sv -----
package pnm_hp_pkg;

    typedef enum logic [3:0] {
        PH_MAGIC_P,
        PH_MAGIC_DIGIT,
        PH_MAGIC_NL,
        PH_DIMS_START,
        PH_DIMS_COMMENT,
        PH_WIDTH,
        PH_HEIGHT_FIRST,
        PH_HEIGHT,
        PH_DEPTH_START,
        PH_DEPTH_COMMENT,
        PH_DEPTH,
        PH_DONE,
        PH_FAILED
    } t_phase;

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_HASH  = 8'd35;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_P     = 8'd80;
    localparam logic [7:0] CH_FIVE  = 8'd53;
    localparam logic [7:0] CH_SIX   = 8'd54;

    localparam int VAL_W = 16;
    localparam int OFS_W = 13;

    typedef struct packed {
        logic              is_colour;
        logic [VAL_W-1:0]  image_width;
        logic [VAL_W-1:0]  image_height;
        logic [VAL_W-1:0]  max_value;
        logic [OFS_W-1:0]  raster_offset;
    } t_result;

    typedef struct packed {
        logic             ok;
        logic [VAL_W-1:0] value;
    } t_digit;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // acc * 10 + digit, flagged when it leaves 16 bits
    function automatic t_digit add_digit(input logic [VAL_W-1:0] acc, input logic [7:0] b);
        logic [VAL_W+3:0] sum;
        t_digit           res;
        sum = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {12'b0, b - CH_ZERO};
        res.ok    = (sum[VAL_W+3:VAL_W] == 4'b0);
        res.value = sum[VAL_W-1:0];
        return res;
    endfunction

endpackage

// ----- src/pnm_header_parser_unit.sv -----
// A result is registered into the output register, or into the skid entry when the
// output register still holds one. Throughput: one byte per cycle while the skid entry
// is empty; the phase update and the times-ten accumulate finish in the accept cycle,
// and a two-entry output buffer keeps input flowing while one result waits downstream.
// Reset (synchronous, active low): parser waits for the magic 'P', counters clear,
// output buffer empties.
module pnm_header_parser_unit
    import pnm_hp_pkg::*;
#(
    parameter int HEADER_LIMIT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] first_of_file
    input  logic        i_s_tlast,   // last_of_file
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [0] is_colour, [16:1] image_width,
                                     // [32:17] image_height, [48:33] max_value,
                                     // [61:49] raster_offset, [63:62] zero
    output logic        o_m_tuser    // [0] parse_status
);

    localparam int CW = $clog2(HEADER_LIMIT + 1);
    localparam logic [CW-1:0] LIMIT_C = HEADER_LIMIT[CW-1:0];

    t_phase           r_phase, n_phase;
    logic             r_colour, n_colour;
    logic [VAL_W-1:0] r_width, n_width;
    logic [VAL_W-1:0] r_height, n_height;
    logic [VAL_W-1:0] r_depth, n_depth;
    logic [CW-1:0]    r_count, n_count;

    logic             r_out_valid, r_out_err;
    t_result          r_out_data;
    logic             r_sk_valid, r_sk_err;
    t_result          r_sk_data;

    logic             accept, pop;
    logic             res_valid, res_err;
    t_result          res_data;

    t_phase           e_phase;
    logic [VAL_W-1:0] e_width, e_height, e_depth;
    logic [CW-1:0]    e_count, inc_count;
    logic [CW+OFS_W-1:0] count_ext;
    t_digit           dw, dh, dd;
    logic             ok;
    logic [7:0]       b;

    assign accept     = i_s_tvalid && o_s_tready;
    assign pop        = r_out_valid && i_m_tready;
    assign o_s_tready = !r_sk_valid;
    assign b          = i_s_tdata;

    assign e_phase  = i_s_tuser ? PH_MAGIC_P : r_phase;
    assign e_width  = i_s_tuser ? '0 : r_width;
    assign e_height = i_s_tuser ? '0 : r_height;
    assign e_depth  = i_s_tuser ? '0 : r_depth;
    assign e_count  = i_s_tuser ? '0 : r_count;
    assign inc_count = e_count + 1'b1;
    assign count_ext = {{OFS_W{1'b0}}, inc_count};

    assign dw = add_digit(e_width, b);
    assign dh = add_digit(e_height, b);
    assign dd = add_digit(e_depth, b);

    always_comb begin
        n_phase  = e_phase;
        n_colour = i_s_tuser ? 1'b0 : r_colour;
        n_width  = e_width;
        n_height = e_height;
        n_depth  = e_depth;
        n_count  = e_count;
        ok       = 1'b1;
        res_valid = 1'b0;
        res_err   = 1'b0;
        res_data  = '0;
        if (e_phase != PH_DONE && e_phase != PH_FAILED) begin
            if (e_count == LIMIT_C) begin
                ok = 1'b0;
            end else begin
                n_count = inc_count;
                unique case (e_phase)
                    PH_MAGIC_P: begin
                        if (b == CH_P) n_phase = PH_MAGIC_DIGIT; else ok = 1'b0;
                    end
                    PH_MAGIC_DIGIT: begin
                        if (b == CH_FIVE) begin
                            n_colour = 1'b0;
                            n_phase  = PH_MAGIC_NL;
                        end else if (b == CH_SIX) begin
                            n_colour = 1'b1;
                            n_phase  = PH_MAGIC_NL;
                        end else begin
                            ok = 1'b0;
                        end
                    end
                    PH_MAGIC_NL: begin
                        if (b == CH_NL) n_phase = PH_DIMS_START; else ok = 1'b0;
                    end
                    PH_DIMS_START: begin
                        if (b == CH_HASH) begin
                            n_phase = PH_DIMS_COMMENT;
                        end else if (is_digit(b)) begin
                            ok      = dw.ok;
                            n_width = dw.value;
                            n_phase = PH_WIDTH;
                        end else if (b != CH_NL) begin
                            ok = 1'b0;
                        end
                    end
                    PH_DIMS_COMMENT: begin
                        if (b == CH_NL) n_phase = PH_DIMS_START;
                    end
                    PH_WIDTH: begin
                        if (is_digit(b)) begin
                            ok      = dw.ok;
                            n_width = dw.value;
                        end else if (b == CH_SPACE) begin
                            n_phase = PH_HEIGHT_FIRST;
                        end else begin
                            ok = 1'b0;
                        end
                    end
                    PH_HEIGHT_FIRST: begin
                        if (is_digit(b)) begin
                            ok       = dh.ok;
                            n_height = dh.value;
                            n_phase  = PH_HEIGHT;
                        end else begin
                            ok = 1'b0;
                        end
                    end
                    PH_HEIGHT: begin
                        if (is_digit(b)) begin
                            ok       = dh.ok;
                            n_height = dh.value;
                        end else if (b == CH_NL) begin
                            n_phase = PH_DEPTH_START;
                        end else begin
                            ok = 1'b0;
                        end
                    end
                    PH_DEPTH_START: begin
                        if (b == CH_HASH) begin
                            n_phase = PH_DEPTH_COMMENT;
                        end else if (is_digit(b)) begin
                            ok      = dd.ok;
                            n_depth = dd.value;
                            n_phase = PH_DEPTH;
                        end else if (b != CH_NL) begin
                            ok = 1'b0;
                        end
                    end
                    PH_DEPTH_COMMENT: begin
                        if (b == CH_NL) n_phase = PH_DEPTH_START;
                    end
                    PH_DEPTH: begin
                        if (is_digit(b)) begin
                            ok      = dd.ok;
                            n_depth = dd.value;
                        end else if (b == CH_NL) begin
                            n_phase = PH_DONE;
                        end else begin
                            ok = 1'b0;
                        end
                    end
                    default: ok = 1'b0;
                endcase
            end

            if (!ok) begin
                n_phase   = PH_FAILED;
                res_valid = 1'b1;
                res_err   = 1'b1;
            end else if (n_phase == PH_DONE) begin
                res_valid              = 1'b1;
                res_data.is_colour     = n_colour;
                res_data.image_width   = n_width;
                res_data.image_height  = n_height;
                res_data.max_value     = n_depth;
                res_data.raster_offset = count_ext[OFS_W-1:0];
            end else if (i_s_tlast) begin
                n_phase   = PH_FAILED;
                res_valid = 1'b1;
                res_err   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC_P;
            r_colour <= 1'b0;
            r_width  <= '0;
            r_height <= '0;
            r_depth  <= '0;
            r_count  <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_colour <= n_colour;
            r_width  <= n_width;
            r_height <= n_height;
            r_depth  <= n_depth;
            r_count  <= n_count;
        end
    end

    // output register plus one skid entry; input stalls only when both hold a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_sk_valid) begin
                r_out_valid <= 1'b1;
                r_sk_valid  <= 1'b0;
            end else begin
                r_out_valid <= accept && res_valid;
            end
        end else if (accept && res_valid) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            if (r_sk_valid) begin
                r_out_data <= r_sk_data;
                r_out_err  <= r_sk_err;
            end else begin
                r_out_data <= res_data;
                r_out_err  <= res_err;
            end
        end else if (accept && res_valid) begin
            r_sk_data <= res_data;
            r_sk_err  <= res_err;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_err;
    assign o_m_tdata  = {2'b00, r_out_data.raster_offset, r_out_data.max_value,
                         r_out_data.image_height, r_out_data.image_width,
                         r_out_data.is_colour};

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_error_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == 64'b0))
        else $error("error result carries nonzero payload");

    a_result_ends_parse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && res_valid) |=> (r_phase == PH_DONE || r_phase == PH_FAILED))
        else $error("parser kept running after a result");

    a_no_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_s_tuser && (r_phase == PH_DONE || r_phase == PH_FAILED)) |-> !res_valid)
        else $error("result raised after header finished");

endmodule

// ----- test/testbench.sv -----
module testbench
    import pnm_hp_pkg::*;
();

    localparam int HDR_LIMIT = 4096;

    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       last;
    } t_byte_item;

    typedef struct {
        logic        status;
        logic        colour;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] maxval;
        logic [12:0] offset;
    } t_header_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'h00;
    logic        i_s_tuser = 1'b0;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;
    logic        o_m_tuser;

    t_byte_item     file_stream[$];
    logic [7:0]     file_bytes[$];
    t_header_report header_reports[$];

    // header parser state as predicted
    t_phase phase = PH_MAGIC_P;
    logic   colour = 1'b0;
    int     width_acc = 0;
    int     height_acc = 0;
    int     depth_acc = 0;
    int     hdr_len = 0;

    int   errors = 0;
    int   cycle_cnt = 0;
    int   hold_cnt = 0;
    logic in_fire = 1'b0;
    logic quiet;

    pnm_header_parser_unit #(.HEADER_LIMIT(HDR_LIMIT)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    assign quiet = (cycle_cnt >= 1000) && (cycle_cnt < 1600);

    task automatic take_digit(inout int acc, input logic [7:0] b, inout logic ok);
        int v;
        v = acc * 10 + int'(b - CH_ZERO);
        if (v > 65535) ok = 1'b0;
        else acc = v;
    endtask

    task automatic report_error();
        t_header_report r;
        phase = PH_FAILED;
        r = '{1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 13'd0};
        header_reports.push_back(r);
    endtask

    task automatic parse_header_byte(input t_byte_item it);
        t_header_report r;
        logic           ok;
        logic           dig;
        logic [7:0]     b;
        b = it.data;
        ok = 1'b1;
        dig = (b >= CH_ZERO) && (b <= CH_NINE);
        if (it.first) begin
            phase = PH_MAGIC_P;
            colour = 1'b0;
            width_acc = 0;
            height_acc = 0;
            depth_acc = 0;
            hdr_len = 0;
        end
        if (phase == PH_DONE || phase == PH_FAILED) return;
        hdr_len++;
        if (hdr_len > HDR_LIMIT) begin
            report_error();
            return;
        end
        case (phase)
            PH_MAGIC_P: begin
                if (b == CH_P) phase = PH_MAGIC_DIGIT;
                else ok = 1'b0;
            end
            PH_MAGIC_DIGIT: begin
                if (b == CH_FIVE || b == CH_SIX) begin
                    colour = (b == CH_SIX);
                    phase = PH_MAGIC_NL;
                end else ok = 1'b0;
            end
            PH_MAGIC_NL: begin
                if (b == CH_NL) phase = PH_DIMS_START;
                else ok = 1'b0;
            end
            PH_DIMS_START: begin
                if (b == CH_HASH) phase = PH_DIMS_COMMENT;
                else if (dig) begin
                    take_digit(width_acc, b, ok);
                    phase = PH_WIDTH;
                end else if (b != CH_NL) ok = 1'b0;
            end
            PH_DIMS_COMMENT: begin
                if (b == CH_NL) phase = PH_DIMS_START;
            end
            PH_WIDTH: begin
                if (dig) take_digit(width_acc, b, ok);
                else if (b == CH_SPACE) phase = PH_HEIGHT_FIRST;
                else ok = 1'b0;
            end
            PH_HEIGHT_FIRST: begin
                if (dig) begin
                    take_digit(height_acc, b, ok);
                    phase = PH_HEIGHT;
                end else ok = 1'b0;
            end
            PH_HEIGHT: begin
                if (dig) take_digit(height_acc, b, ok);
                else if (b == CH_NL) phase = PH_DEPTH_START;
                else ok = 1'b0;
            end
            PH_DEPTH_START: begin
                if (b == CH_HASH) phase = PH_DEPTH_COMMENT;
                else if (dig) begin
                    take_digit(depth_acc, b, ok);
                    phase = PH_DEPTH;
                end else if (b != CH_NL) ok = 1'b0;
            end
            PH_DEPTH_COMMENT: begin
                if (b == CH_NL) phase = PH_DEPTH_START;
            end
            PH_DEPTH: begin
                if (dig) take_digit(depth_acc, b, ok);
                else if (b == CH_NL) phase = PH_DONE;
                else ok = 1'b0;
            end
            default: ok = 1'b0;
        endcase
        if (!ok) report_error();
        else if (phase == PH_DONE) begin
            r = '{1'b0, colour, width_acc[15:0], height_acc[15:0], depth_acc[15:0],
                  hdr_len[12:0]};
            header_reports.push_back(r);
        end else if (it.last) report_error();
    endtask

    task automatic check_field(input string name, input logic [15:0] expv,
                               input logic [15:0] actv);
        if (actv !== expv) begin
            $error("%s: expected %0d, actual %0d", name, expv, actv);
            errors++;
        end
    endtask

    // check the output first, then predict from the byte taken at this edge
    always @(posedge i_clk) begin
        t_header_report exp_r;
        t_byte_item     it;
        cycle_cnt++;
        in_fire = i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (header_reports.size() == 0) begin
                $error("result with none expected: tuser %0b tdata %h", o_m_tuser, o_m_tdata);
                errors++;
            end else begin
                exp_r = header_reports.pop_front();
                check_field("parse_status", 16'(exp_r.status), 16'(o_m_tuser));
                check_field("is_colour", 16'(exp_r.colour), 16'(o_m_tdata[0]));
                check_field("image_width", exp_r.width, o_m_tdata[16:1]);
                check_field("image_height", exp_r.height, o_m_tdata[32:17]);
                check_field("max_value", exp_r.maxval, o_m_tdata[48:33]);
                check_field("raster_offset", 16'(exp_r.offset), 16'(o_m_tdata[61:49]));
                check_field("tdata_pad", 16'd0, 16'(o_m_tdata[63:62]));
            end
        end
        if (in_fire) begin
            it.data = i_s_tdata;
            it.first = i_s_tuser;
            it.last = i_s_tlast;
            parse_header_byte(it);
        end
    end

    always @(negedge i_clk) begin
        t_byte_item it;
        logic       give;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || in_fire) begin
            give = (file_stream.size() != 0) && (quiet || $urandom_range(99) >= 7);
            if (give) begin
                it = file_stream.pop_front();
                i_s_tdata <= it.data;
                i_s_tuser <= it.first;
                i_s_tlast <= it.last;
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // one long hold-off lets results pile up until the input stalls
    always @(negedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt = hold_cnt - 1;
            i_m_tready <= 1'b0;
        end else if (cycle_cnt == 400) begin
            hold_cnt = 300;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= quiet || ($urandom_range(99) >= 7);
        end
    end

    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++) file_bytes.push_back(s[k]);
    endtask

    task automatic put_number(input int v);
        int zeros;
        zeros = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0;
        repeat (zeros) file_bytes.push_back(CH_ZERO);
        put_text($sformatf("%0d", v));
    endtask

    task automatic put_comment_body(input int n);
        int v;
        repeat (n) begin
            v = $urandom_range(254);
            if (v >= CH_NL) v++;
            file_bytes.push_back(v[7:0]);
        end
    endtask

    task automatic put_filler();
        repeat ($urandom_range(2)) begin
            if ($urandom_range(1)) begin
                file_bytes.push_back(CH_NL);
            end else begin
                file_bytes.push_back(CH_HASH);
                put_comment_body($urandom_range(8));
                file_bytes.push_back(CH_NL);
            end
        end
    endtask

    function automatic int pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 50) return $urandom_range(999);
        if (r < 80) return $urandom_range(65535);
        if (r < 90) return $urandom_range(1) ? 65535 - $urandom_range(5) : 0;
        return $urandom_range(999999, 65536);
    endfunction

    task automatic emit_file(input logic first, input logic last_end);
        t_byte_item it;
        for (int k = 0; k < file_bytes.size(); k++) begin
            it.data = file_bytes[k];
            it.first = first && (k == 0);
            it.last = last_end && (k == file_bytes.size() - 1);
            file_stream.push_back(it);
        end
        file_bytes.delete();
    endtask

    task automatic send_text(input string s, input logic first, input logic last_end);
        put_text(s);
        emit_file(first, last_end);
    endtask

    task automatic add_random_file(output int counted);
        t_byte_item it;
        int         mode;
        int         cut;
        int         n;
        logic       last_end;
        mode = $urandom_range(99);
        if (mode < 5) begin
            // raw noise with random flags
            n = $urandom_range(1, 6);
            repeat (n) begin
                it.data = 8'($urandom_range(255));
                it.first = 1'($urandom_range(1));
                it.last = 1'($urandom_range(1));
                file_stream.push_back(it);
            end
            counted = n;
            return;
        end
        put_text($urandom_range(1) ? "P6\n" : "P5\n");
        put_filler();
        put_number(pick_value());
        put_text(" ");
        put_number(pick_value());
        put_text("\n");
        put_filler();
        put_number(pick_value());
        put_text("\n");
        counted = file_bytes.size();
        last_end = 1'b0;
        if (mode < 15) begin
            file_bytes[$urandom_range(file_bytes.size() - 1)] = 8'($urandom_range(255));
        end else if (mode < 25) begin
            // truncated file: end of file inside the header or on its last byte
            cut = $urandom_range(file_bytes.size() - 1);
            while (file_bytes.size() > cut + 1) void'(file_bytes.pop_back());
            counted = file_bytes.size();
            last_end = 1'b1;
        end else begin
            n = $urandom_range(3);
            repeat (n) file_bytes.push_back(8'($urandom_range(255)));
            last_end = (n != 0) && $urandom_range(1);
        end
        emit_file($urandom_range(19) != 0, last_end);
    endtask

    initial begin
        int total;
        int got;
        // no restart flag after reset, trailing raster bytes ignored
        send_text("P6\n3 2\n255\nxy", 1'b0, 1'b1);
        send_text("P5\n#c\n\n0 0\n#x\n\n65535\n", 1'b1, 1'b0);
        send_text("P6\n65535 65535\n0\n", 1'b1, 1'b0);
        send_text("P5\n007 08\n#\n099\n", 1'b1, 1'b0);
        send_text("P5\n65536 1\n", 1'b1, 1'b0);
        send_text("P5\n1 1\n99999\n", 1'b1, 1'b0);
        send_text("P7", 1'b1, 1'b0);
        send_text("Q", 1'b1, 1'b0);
        send_text("P5 ", 1'b1, 1'b0);
        send_text("P5\n 1", 1'b1, 1'b0);
        send_text("P5\n1  2", 1'b1, 1'b0);
        send_text("P5\n1 \n", 1'b1, 1'b0);
        send_text("P5\n1 1\nx", 1'b1, 1'b0);
        send_text("P5\n12 3", 1'b1, 1'b1);
        send_text("P", 1'b1, 1'b1);
        send_text("P6\n1 1\n1\n", 1'b1, 1'b1);
        total = 0;
        while (total < 1550) begin
            add_random_file(got);
            total += got;
        end
        send_text("P5\n4 4\n15\n", 1'b1, 1'b0);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (file_stream.size() != 0 || i_s_tvalid) @(posedge i_clk);
        while (header_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end
endmodule

// ----- files.f -----
src/pnm_hp_pkg.sv
src/pnm_header_parser_unit.sv
test/testbench.sv
